// ===== rtl/urln_pkg.sv =====
// Shared types, character constants and small character helpers for the
// streaming URL normalizer. No dependencies.
package urln_pkg;

    // Results that one input byte can cause at most: ':' '-' ten digits '/'
    localparam int MAX_RES     = 13;
    localparam int CNT_W       = 4;
    localparam int PORT_DIGITS = 10;
    localparam int DIG_IDX_W   = 4;

    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_QMARK   = 8'h3F;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_TILDE   = 8'h7E;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_H       = 8'h68;
    localparam logic [7:0] CH_T       = 8'h74;
    localparam logic [7:0] CH_P       = 8'h70;
    localparam logic [7:0] CH_S       = 8'h73;

    // Largest magnitudes of a 32-bit signed int, as packed decimal digits
    localparam logic [4*PORT_DIGITS-1:0] LIM_POS = 40'h2147483647;
    localparam logic [4*PORT_DIGITS-1:0] LIM_NEG = 40'h2147483648;

    typedef enum logic [2:0] {
        PH_PREFIX    = 3'd0,
        PH_REJECT    = 3'd1,
        PH_HOST      = 3'd2,
        PH_PORT      = 3'd3,
        PH_PORT_SKIP = 3'd4,
        PH_PATH      = 3'd5,
        PH_QUERY     = 3'd6,
        PH_FRAG      = 3'd7
    } urln_phase_t;

    typedef logic [MAX_RES-1:0][7:0] urln_bytes_t;

    // All results caused by one input byte, head at index 0
    typedef struct packed {
        urln_bytes_t        bytes;
        logic [CNT_W-1:0]   cnt;
        logic               has;
        logic               ok;
        logic               last;
    } urln_group_t;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? (c | 8'h20) : c;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39);
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_digit(c) || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        return is_digit(c) ? c[3:0] : 4'(c[3:0] + 4'd9);
    endfunction

    function automatic logic is_unreserved(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) || is_digit(c) ||
               c == CH_MINUS || c == CH_DOT || c == CH_UNDER || c == CH_TILDE;
    endfunction

    function automatic logic [7:0] scheme_char(input logic [1:0] idx);
        logic [7:0] ch;
        unique case (idx)
            2'd0:    ch = CH_H;
            2'd1:    ch = CH_T;
            2'd2:    ch = CH_T;
            default: ch = CH_P;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] sep_char(input logic [1:0] idx);
        logic [7:0] ch;
        unique case (idx)
            2'd0:    ch = CH_COLON;
            default: ch = CH_SLASH;
        endcase
        return ch;
    endfunction

endpackage

// ===== rtl/urln_parse.sv =====
// URL parser: phase state, port digit store and escape state, and the
// combinational build of all result bytes one input byte causes. Uses urln_pkg.
module urln_parse (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 take,
    input  logic [7:0]           in_byte,
    input  logic                 in_last,
    output urln_pkg::urln_group_t grp
);
    import urln_pkg::*;

    urln_phase_t          phase_reg, phase_next;
    logic [2:0]           pos_reg, pos_next;
    logic                 sec_reg, sec_next;
    logic [CNT_W-1:0]     len_reg, len_next;
    logic                 neg_reg, neg_next;
    logic                 inv_reg, inv_next;
    logic [1:0]           esc_reg, esc_next;
    logic [7:0]           held_reg, held_next;
    logic                 qmark_reg, qmark_next;
    logic [3:0]           dig_reg [PORT_DIGITS];

    // port update results
    logic [CNT_W-1:0]     len_upd;
    logic                 neg_upd;
    logic                 inv_upd;
    logic                 to_skip;
    logic                 dig_we;
    logic [DIG_IDX_W-1:0] dig_idx;
    logic [3:0]           dig_upd [PORT_DIGITS];

    // authority end sequence
    urln_bytes_t          e_bytes;
    logic [CNT_W-1:0]     e_cnt;
    logic [CNT_W-1:0]     e_end;
    logic                 port_act;
    logic                 port_ok;
    logic                 dash;
    logic                 ovf;
    logic                 minus_one;
    logic                 dflt;
    logic [4*PORT_DIGITS-1:0] bcd;
    logic [7:0]           cand_nd [MAX_RES];
    logic [7:0]           cand_d  [MAX_RES];

    logic [7:0]           lc;
    logic                 is_term;
    logic [2:0]           k3;
    logic [7:0]           dec_v;
    logic [7:0]           x_val;
    logic                 x_en;
    urln_group_t          g;

    assign lc      = to_lower(in_byte);
    assign is_term = (in_byte == CH_SLASH) || (in_byte == CH_QMARK) || (in_byte == CH_HASH);
    assign k3      = 3'(pos_reg - 3'd4 - {2'b00, sec_reg});
    assign dec_v   = {hex_val(held_reg), hex_val(in_byte)};

    // Update the port parse with a non-terminating byte in the port phase
    always_comb begin
        len_upd = len_reg;
        neg_upd = neg_reg;
        inv_upd = inv_reg;
        to_skip = 1'b0;
        dig_we  = 1'b0;
        dig_idx = len_reg;
        if (phase_reg == PH_PORT && !is_term) begin
            if (is_digit(in_byte)) begin
                if (len_reg == '0) begin
                    dig_we  = 1'b1;
                    dig_idx = '0;
                    len_upd = CNT_W'(1);
                end else if (len_reg == CNT_W'(1) && dig_reg[0] == 4'd0) begin
                    dig_we  = 1'b1;
                    dig_idx = '0;
                end else if (len_reg < CNT_W'(PORT_DIGITS)) begin
                    dig_we  = 1'b1;
                    len_upd = len_reg + CNT_W'(1);
                end else begin
                    inv_upd = 1'b1;
                end
            end else if (in_byte == CH_MINUS && len_reg == '0 && !neg_reg) begin
                neg_upd = 1'b1;
            end else begin
                if (len_reg == '0) begin
                    inv_upd = 1'b1;
                end
                to_skip = 1'b1;
            end
        end
    end

    // Digit store as it stands after this byte
    always_comb begin
        for (int i = 0; i < PORT_DIGITS; i++) begin
            dig_upd[i] = (dig_we && dig_idx == DIG_IDX_W'(i)) ? in_byte[3:0] : dig_reg[i];
        end
    end

    // Build the authority end: optional ":[-]digits", then '/'
    always_comb begin
        for (int i = 0; i < PORT_DIGITS; i++) begin
            bcd[4*(PORT_DIGITS-1-i) +: 4] = dig_upd[i];
        end
        port_act  = (phase_reg == PH_PORT) || (phase_reg == PH_PORT_SKIP);
        minus_one = neg_upd && len_upd == CNT_W'(1) && dig_upd[0] == 4'd1;
        dash      = neg_upd && !(len_upd == CNT_W'(1) && dig_upd[0] == 4'd0);
        ovf       = (len_upd == CNT_W'(PORT_DIGITS)) && (bcd > (neg_upd ? LIM_NEG : LIM_POS));
        dflt      = !neg_upd &&
                    ((!sec_reg && len_upd == CNT_W'(2) && dig_upd[0] == 4'd8 &&
                      dig_upd[1] == 4'd0) ||
                     (sec_reg && len_upd == CNT_W'(3) && dig_upd[0] == 4'd4 &&
                      dig_upd[1] == 4'd4 && dig_upd[2] == 4'd3));
        port_ok   = port_act && len_upd != '0 && !inv_upd && !ovf && !minus_one && !dflt;
        e_end     = {3'b000, dash} + len_upd + CNT_W'(1);

        cand_nd[0] = CH_COLON;
        cand_d[0]  = CH_COLON;
        cand_d[1]  = CH_MINUS;
        for (int i = 0; i < PORT_DIGITS; i++) begin
            cand_nd[i+1] = CH_ZERO | {4'h0, dig_upd[i]};
            cand_d[i+2]  = CH_ZERO | {4'h0, dig_upd[i]};
        end
        cand_nd[11] = 8'h00;
        cand_nd[12] = 8'h00;
        cand_d[12]  = 8'h00;

        for (int j = 0; j < MAX_RES; j++) begin
            if (!port_ok) begin
                e_bytes[j] = (j == 0) ? CH_SLASH : 8'h00;
            end else if (CNT_W'(j) < e_end) begin
                e_bytes[j] = dash ? cand_d[j] : cand_nd[j];
            end else if (CNT_W'(j) == e_end) begin
                e_bytes[j] = CH_SLASH;
            end else begin
                e_bytes[j] = 8'h00;
            end
        end
        e_cnt = port_ok ? e_end + CNT_W'(1) : CNT_W'(1);
    end

    // Per-phase next state and result bytes
    always_comb begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        sec_next   = sec_reg;
        len_next   = len_upd;
        neg_next   = neg_upd;
        inv_next   = inv_upd;
        esc_next   = esc_reg;
        held_next  = held_reg;
        qmark_next = qmark_reg;
        x_val      = in_byte;
        x_en       = 1'b0;
        g          = '0;
        g.has      = 1'b1;
        g.ok       = 1'b1;

        unique case (phase_reg)
            PH_PREFIX: begin
                if (pos_reg < 3'd4) begin
                    if (lc == scheme_char(pos_reg[1:0])) begin
                        pos_next = pos_reg + 3'd1;
                    end else begin
                        phase_next = PH_REJECT;
                    end
                end else if (pos_reg == 3'd4 && !sec_reg && lc == CH_S) begin
                    sec_next = 1'b1;
                    pos_next = 3'd5;
                end else if (k3 > 3'd2 || in_byte != sep_char(k3[1:0])) begin
                    phase_next = PH_REJECT;
                end else if (k3 < 3'd2) begin
                    pos_next = pos_reg + 3'd1;
                end else begin
                    // prefix complete: emit the lower-case scheme and separator
                    g.bytes[0] = CH_H;
                    g.bytes[1] = CH_T;
                    g.bytes[2] = CH_T;
                    g.bytes[3] = CH_P;
                    if (sec_reg) begin
                        g.bytes[4] = CH_S;
                        g.bytes[5] = CH_COLON;
                        g.bytes[6] = CH_SLASH;
                        g.bytes[7] = CH_SLASH;
                        g.bytes[8] = in_last ? CH_SLASH : 8'h00;
                        g.cnt      = in_last ? CNT_W'(9) : CNT_W'(8);
                    end else begin
                        g.bytes[4] = CH_COLON;
                        g.bytes[5] = CH_SLASH;
                        g.bytes[6] = CH_SLASH;
                        g.bytes[7] = in_last ? CH_SLASH : 8'h00;
                        g.cnt      = in_last ? CNT_W'(8) : CNT_W'(7);
                    end
                    pos_next   = 3'd0;
                    phase_next = PH_HOST;
                end
            end
            PH_REJECT: begin
            end
            PH_HOST, PH_PORT, PH_PORT_SKIP: begin
                if (is_term) begin
                    g.bytes = e_bytes;
                    g.cnt   = e_cnt;
                    if (in_byte == CH_SLASH) begin
                        phase_next = PH_PATH;
                    end else if (in_byte == CH_QMARK) begin
                        qmark_next = 1'b1;
                        phase_next = PH_QUERY;
                    end else begin
                        phase_next = PH_FRAG;
                    end
                end else begin
                    if (phase_reg == PH_HOST) begin
                        if (in_byte == CH_COLON) begin
                            phase_next = PH_PORT;
                        end else begin
                            g.bytes[0] = lc;
                            g.cnt      = CNT_W'(1);
                        end
                    end else if (to_skip) begin
                        phase_next = PH_PORT_SKIP;
                    end
                    // close the authority on the final byte
                    if (in_last) begin
                        if (g.cnt != '0) begin
                            g.bytes[1] = CH_SLASH;
                            g.cnt      = CNT_W'(2);
                        end else begin
                            g.bytes = e_bytes;
                            g.cnt   = e_cnt;
                        end
                    end
                end
            end
            PH_PATH: begin
                if (esc_reg == 2'd1 && is_hex(in_byte)) begin
                    held_next = in_byte;
                    esc_next  = 2'd2;
                    if (in_last) begin
                        g.bytes[0] = CH_PERCENT;
                        g.bytes[1] = in_byte;
                        g.cnt      = CNT_W'(2);
                    end
                end else if (esc_reg == 2'd2 && is_hex(in_byte)) begin
                    esc_next = 2'd0;
                    if (is_unreserved(dec_v)) begin
                        g.bytes[0] = dec_v;
                        g.cnt      = CNT_W'(1);
                    end else begin
                        g.bytes[0] = CH_PERCENT;
                        g.bytes[1] = held_reg;
                        g.bytes[2] = in_byte;
                        g.cnt      = CNT_W'(3);
                    end
                end else begin
                    // flush a pending escape, then handle the byte itself
                    if (esc_reg != 2'd0) begin
                        g.bytes[0] = CH_PERCENT;
                    end
                    if (esc_reg[1]) begin
                        g.bytes[1] = held_reg;
                    end
                    esc_next = 2'd0;
                    if (in_byte == CH_PERCENT) begin
                        esc_next = 2'd1;
                        x_en     = in_last;
                    end else if (in_byte == CH_QMARK) begin
                        qmark_next = 1'b1;
                        phase_next = PH_QUERY;
                    end else if (in_byte == CH_HASH) begin
                        phase_next = PH_FRAG;
                    end else begin
                        x_en = 1'b1;
                    end
                    if (x_en) begin
                        g.bytes[{2'b00, esc_reg}] = x_val;
                    end
                    g.cnt = {2'b00, esc_reg} + {3'b000, x_en};
                end
            end
            PH_QUERY: begin
                if (in_byte == CH_HASH) begin
                    qmark_next = 1'b0;
                    phase_next = PH_FRAG;
                end else if (qmark_reg) begin
                    qmark_next = 1'b0;
                    g.bytes[0] = CH_QMARK;
                    g.bytes[1] = in_byte;
                    g.cnt      = CNT_W'(2);
                end else begin
                    g.bytes[0] = in_byte;
                    g.cnt      = CNT_W'(1);
                end
            end
            PH_FRAG: begin
            end
            default: begin
            end
        endcase

        // Close the URL: reject item or empty item, mark last, clear state
        if (in_last) begin
            if (phase_next == PH_PREFIX || phase_next == PH_REJECT) begin
                g     = '0;
                g.cnt = CNT_W'(1);
            end else if (g.cnt == '0) begin
                g.bytes = '0;
                g.cnt   = CNT_W'(1);
                g.has   = 1'b0;
                g.ok    = 1'b1;
            end
            g.last     = 1'b1;
            phase_next = PH_PREFIX;
            pos_next   = 3'd0;
            sec_next   = 1'b0;
            len_next   = '0;
            neg_next   = 1'b0;
            inv_next   = 1'b0;
            esc_next   = 2'd0;
            held_next  = 8'h00;
            qmark_next = 1'b0;
        end
    end

    assign grp = g;

    // Advance the parse state on each accepted transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_PREFIX;
            pos_reg   <= 3'd0;
            sec_reg   <= 1'b0;
            len_reg   <= '0;
            neg_reg   <= 1'b0;
            inv_reg   <= 1'b0;
            esc_reg   <= 2'd0;
            held_reg  <= 8'h00;
            qmark_reg <= 1'b0;
        end else if (take) begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            sec_reg   <= sec_next;
            len_reg   <= len_next;
            neg_reg   <= neg_next;
            inv_reg   <= inv_next;
            esc_reg   <= esc_next;
            held_reg  <= held_next;
            qmark_reg <= qmark_next;
        end
    end

    // Store port digits; entries hold stale values until rewritten
    always_ff @(posedge aclk) begin
        if (take && dig_we) begin
            dig_reg[dig_idx] <= in_byte[3:0];
        end
    end

endmodule

// ===== rtl/urln_emit.sv =====
// Result side: holds the byte group of one transaction, shifts it out one
// result per cycle, unless the receiver stalls, into the output register. Uses urln_pkg.
module urln_emit (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  load,
    input  urln_pkg::urln_group_t grp,
    output logic                  ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [7:0]            m_out_byte,
    output logic                  m_has_byte,
    output logic                  m_url_ok,
    output logic                  m_out_last
);
    import urln_pkg::*;

    urln_bytes_t      bytes_reg, bytes_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             has_reg, has_next;
    logic             ok_reg, ok_next;
    logic             last_reg, last_next;

    logic             valid_reg, valid_next;
    logic [7:0]       byte_reg, byte_next;
    logic             obyte_has_reg, obyte_has_next;
    logic             url_ok_reg, url_ok_next;
    logic             out_last_reg, out_last_next;

    logic             pop;

    assign pop   = (cnt_reg != '0) && (!valid_reg || m_ready);
    assign ready = (cnt_reg == '0) || (cnt_reg == CNT_W'(1) && pop);

    // Shift the group on each pop, load a new group when one arrives
    always_comb begin
        bytes_next = bytes_reg;
        cnt_next   = cnt_reg - {{(CNT_W-1){1'b0}}, pop};
        has_next   = has_reg;
        ok_next    = ok_reg;
        last_next  = last_reg;
        if (pop) begin
            bytes_next = {8'h00, bytes_reg[MAX_RES-1:1]};
        end
        if (load && grp.cnt != '0) begin
            bytes_next = grp.bytes;
            cnt_next   = grp.cnt;
            has_next   = grp.has;
            ok_next    = grp.ok;
            last_next  = grp.last;
        end
    end

    // Output register: fill on pop, drop when the receiver takes it
    always_comb begin
        valid_next     = pop || (valid_reg && !m_ready);
        byte_next      = byte_reg;
        obyte_has_next = obyte_has_reg;
        url_ok_next    = url_ok_reg;
        out_last_next  = out_last_reg;
        if (pop) begin
            byte_next      = has_reg ? bytes_reg[0] : 8'h00;
            obyte_has_next = has_reg;
            url_ok_next    = ok_reg;
            out_last_next  = last_reg && (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        bytes_reg     <= bytes_next;
        has_reg       <= has_next;
        ok_reg        <= ok_next;
        last_reg      <= last_next;
        byte_reg      <= byte_next;
        obyte_has_reg <= obyte_has_next;
        url_ok_reg    <= url_ok_next;
        out_last_reg  <= out_last_next;
    end

    assign m_valid    = valid_reg;
    assign m_out_byte = byte_reg;
    assign m_has_byte = obyte_has_reg;
    assign m_url_ok   = url_ok_reg;
    assign m_out_last = out_last_reg;

endmodule

// ===== rtl/url_normalizer_stream.sv =====
// Streaming URL normalizer: one URL character in per transaction, the
// normalized URL out one character per transaction.
// Depends on urln_pkg, urln_parse and urln_emit.
//
// Input channel (s_): s_in_byte is one URL character, s_in_last marks the
// final character of a URL. Output channel (m_): m_out_byte carries one
// normalized character when m_has_byte is 1; a URL that fails the scheme
// check yields a single item with m_has_byte = 0 and m_url_ok = 0, and a
// final character that yields nothing gives one empty item with
// m_has_byte = 0. m_out_last marks the final item of each URL.
// The first result of an accepted byte passes through the group register and
// then the output register before it appears on m_valid.
// Throughput: one result per cycle while m_ready is high. A byte that yields
// zero or one results is then taken every cycle; a byte that yields k results
// (up to 13, for the scheme or a long port) holds s_ready low while the
// group register drains into the output register one result per cycle.
// When the receiver stalls, the output and group registers hold, and s_ready
// stays low while the group register holds a result that cannot move on.
// Reset empties both registers and clears all parse state but the port digits.
module url_normalizer_stream (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_in_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_has_byte,
    output logic       m_url_ok,
    output logic       m_out_last
);
    import urln_pkg::*;

    urln_group_t grp;
    logic        take;

    assign take = s_valid && s_ready;

    // Parse each accepted byte into its group of results
    urln_parse u_parse (
        .aclk    (aclk),
        .aresetn (aresetn),
        .take    (take),
        .in_byte (s_in_byte),
        .in_last (s_in_last),
        .grp     (grp)
    );

    // Drain groups onto the result channel
    urln_emit u_emit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (take),
        .grp        (grp),
        .ready      (s_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_has_byte (m_has_byte),
        .m_url_ok   (m_url_ok),
        .m_out_last (m_out_last)
    );

endmodule
